### src/deq_pkg.sv
// Shared types and codes for the double-ended queue unit.
package deq_pkg;

  // Request codes carried by each input word
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming request word
    logic execute;   // perform the request and load the result register
  } deq_cmd_t;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned OCC_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

### src/deq_if.sv
// Valid/ready channel interfaces for request and result words.
interface deq_in_if;
  import deq_pkg::*;
  logic                      valid;
  logic                      ready;
  req_t                      req_type;
  logic signed [WORD_W-1:0]  push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  pop_value;
  status_t                   status;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

### src/deq_ctrl.sv
// Controller: request sequencing and result register handshake.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output deq_pkg::deq_cmd_t cmd
);
  import deq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // run only once the result register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### src/deq_dp.sv
// Datapath: entry store, head pointer, entry count and result register.
module deq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  deq_pkg::deq_cmd_t                 cmd,
  input  logic                              cfg_we,
  input  logic [deq_pkg::CAP_W-1:0]         cfg_data,
  input  deq_pkg::req_t                     req_type,
  input  logic signed [deq_pkg::WORD_W-1:0] push_value,
  output logic signed [deq_pkg::WORD_W-1:0] pop_value,
  output deq_pkg::status_t                  status,
  output logic [deq_pkg::OCC_W-1:0]         occupancy
);
  import deq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  // Add modulo DEPTH; a < DEPTH, b <= DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + (AW+1)'(b);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  logic [WORD_W-1:0]  mem [DEPTH];
  logic [CAP_W-1:0]   cap_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  req_t               req_r;
  logic [WORD_W-1:0]  word_r;
  logic [WORD_W-1:0]  rd_data_r;
  logic               pop_ok_r;
  status_t            stat_r, stat_nxt;
  logic [OCC_W-1:0]   occ_r;

  logic [LW-1:0]      limit_w, cap_w, dep_w;
  logic               is_full, is_empty, wr_en, rd_en, pop_ok;
  logic [AW-1:0]      addr;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  // Effective limit is capacity clipped to the built depth
  assign cap_w    = LW'(cap_r);
  assign dep_w    = LW'(DEPTH);
  assign limit_w  = (cap_w > dep_w) ? dep_w : cap_w;
  assign is_full  = LW'(count_r) >= limit_w;
  assign is_empty = (count_r == '0);

  // Request decode: pointer update, store address and status
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    stat_nxt  = ST_DONE;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    addr      = head_r;
    case (req_r)
      REQ_PUSH_FRONT: begin
        addr = wrap_dec(head_r);
        if (is_full) begin
          stat_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          head_nxt  = addr;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_PUSH_REAR: begin
        addr = wrap_add(head_r, count_r);
        if (is_full) begin
          stat_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        addr = head_r;
        if (is_empty) begin
          stat_nxt = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          head_nxt  = wrap_add(head_r, CW'(1));
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_POP_REAR: begin
        addr = wrap_add(head_r, count_r - CW'(1));
        if (is_empty) begin
          stat_nxt = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        stat_nxt = ST_DONE;
      end
    endcase
  end

  assign pop_ok = rd_en;

  // Pointer and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.execute) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Request word latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_type;
      word_r <= push_value;
    end
  end

  // Entry store, one access per request, registered read
  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      mem[addr] <= word_r;
    end
    if (cmd.execute && rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      pop_ok_r <= pop_ok;
      stat_r   <= stat_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign pop_value = pop_ok_r ? rd_data_r : '0;
  assign status    = stat_r;
  assign occupancy = occ_r;

endmodule

### src/double_ended_queue_unit.sv
// Top level of the double-ended queue unit.
// A deque of signed 32-bit words in a circular store of DEPTH entries
// (2 to 1024). Each request word pushes or pops at the front or rear and
// yields exactly one result word: popped value (zero unless a pop was
// done), status (done, full, empty) and the entry count after the request,
// masked to 5 bits. A request passes through two states: the accept cycle,
// then the execute cycle in which the single store port is read or written and the
// head pointer and count update. The result is held in an output register,
// so the next request is accepted while the previous result still waits;
// a stalled result delays only the execute cycle of the following request.
// cfg_data sets the capacity (reset 16, clipped to DEPTH); write it only
// while the unit is idle. There is no clearing pass after reset.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [deq_pkg::CAP_W-1:0] cfg_data,
  deq_in_if.sink                    in_if,
  deq_out_if.source                 out_if
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .cmd       (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .req_type   (in_if.req_type),
    .push_value (in_if.push_value),
    .pop_value  (out_if.pop_value),
    .status     (out_if.status),
    .occupancy  (out_if.occupancy)
  );

  // Execute only when the result register can take the result
  a_exec_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> (!out_if.valid || out_if.ready))
    else $error("execute while result register is occupied");

  // An executed request always presents a result next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_if.valid)
    else $error("executed request produced no result");

  // Accepting a word closes the input until it has executed
  a_accept_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input reopened before execute");

  // A refused request returns a zero value
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status == ST_FULL || out_if.status == ST_EMPTY))
      |-> (out_if.pop_value == '0))
    else $error("refused request returned a nonzero value");

endmodule

### verif/double_ended_queue_unit_tb.sv
// Self-checking testbench for the double-ended queue unit: directed table, then random traffic.
module double_ended_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int DEPTH          = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STALL_CYCLES   = 80;
  localparam int DRAIN_CYCLES   = 4;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } deq_result_t;

  // One row of the directed table: either a capacity write or a request word
  typedef struct packed {
    bit                       is_cfg;
    logic [CAP_W-1:0]         cap;
    req_t                     req;
    logic signed [WORD_W-1:0] value;
    bit                       typed;
    deq_result_t              want;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  // Shadow copy of the deque
  logic signed [WORD_W-1:0] deque_words [DEPTH];
  int unsigned              front_idx;
  int unsigned              held_count;
  logic [CAP_W-1:0]         capacity_reg;

  deq_result_t pending_results [$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow deque and return the result word it yields
  function automatic deq_result_t apply_deque_request(input req_t req,
                                                      input logic signed [WORD_W-1:0] value);
    deq_result_t res;
    int unsigned limit;
    int unsigned slot;
    res.pop_value = '0;
    res.status    = ST_DONE;
    limit = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
        if (held_count >= limit) begin
          res.status = ST_FULL;
        end else begin
          if (req == REQ_PUSH_FRONT) begin
            front_idx = (front_idx + DEPTH - 1) % DEPTH;
            slot = front_idx;
          end else begin
            slot = (front_idx + held_count) % DEPTH;
          end
          deque_words[slot] = value;
          held_count++;
        end
      end
      default: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (req == REQ_POP_FRONT) begin
            slot = front_idx;
            front_idx = (front_idx + 1) % DEPTH;
          end else begin
            slot = (front_idx + held_count - 1) % DEPTH;
          end
          res.pop_value = deque_words[slot];
          held_count--;
        end
      end
    endcase
    res.occupancy = held_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic stim_row_t cap_row(input logic [CAP_W-1:0] cap);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cap = cap;
    return r;
  endfunction

  function automatic stim_row_t req_row(input req_t req, input logic signed [WORD_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.req = req;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input req_t req,
                                            input logic signed [WORD_W-1:0] value,
                                            input logic signed [WORD_W-1:0] pop,
                                            input status_t st,
                                            input logic [OCC_W-1:0] occ);
    stim_row_t r;
    r = req_row(req, value);
    r.typed = 1'b1;
    r.want.pop_value = pop;
    r.want.status = st;
    r.want.occupancy = occ;
    return r;
  endfunction

  // Extremes, small values and sign-heavy values mixed with full-range noise
  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(5))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $urandom_range(15);
      3:       return 32'hFFFF_FFF0 | $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Offer one request word; called and returns at a falling edge
  task automatic send_word(input req_t req, input logic signed [WORD_W-1:0] value,
                           input bit typed, input deq_result_t want);
    deq_result_t got;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.push_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    got = apply_deque_request(req, value);
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // Wait for the unit to go idle, then write the capacity register
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    capacity_reg = cap;
  endtask

  // Random requests; push share rotates every 30 words unless pinned
  task automatic run_random(input int count, input int fixed_pct);
    int   push_pct;
    req_t req;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (fixed_pct >= 0) begin
        push_pct = fixed_pct;
      end else if (i % 30 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      if ($urandom_range(99) < push_pct)
        req = $urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
      else
        req = $urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT;
      send_word(req, random_word(), 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure, plus one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result word with none expected: pop_value=%0d status=%0d occupancy=%0d",
                   $time, out_ch.pop_value, out_ch.status, out_ch.occupancy);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.pop_value !== want.pop_value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: pop_value expected %0d got %0d",
                     $time, want.pop_value, out_ch.pop_value);
        end
        if (out_ch.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: status expected %0d got %0d", $time, want.status, out_ch.status);
        end
        if (out_ch.occupancy !== want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: occupancy expected %0d got %0d",
                     $time, want.occupancy, out_ch.occupancy);
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    stim_row_t directed_rows [];
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_PUSH_FRONT;
    in_ch.push_value = '0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    rst_n            = 1'b0;
    front_idx        = 0;
    held_count       = 0;
    capacity_reg     = CAP_RESET;
    send_idle_pct    = 20;
    recv_idle_pct    = 48;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_rows = '{
      // empty after reset, then fill both ends with extremes and drain
      checked_row(REQ_POP_FRONT,  32'sd0,          32'sd0,          ST_EMPTY, 5'd0),
      checked_row(REQ_POP_REAR,   32'sd0,          32'sd0,          ST_EMPTY, 5'd0),
      checked_row(REQ_PUSH_FRONT, 32'sh7FFF_FFFF,  32'sd0,          ST_DONE,  5'd1),
      checked_row(REQ_PUSH_REAR,  32'sh8000_0000,  32'sd0,          ST_DONE,  5'd2),
      checked_row(REQ_PUSH_FRONT, 32'sd0,          32'sd0,          ST_DONE,  5'd3),
      checked_row(REQ_PUSH_REAR,  -32'sd1,         32'sd0,          ST_DONE,  5'd4),
      checked_row(REQ_POP_FRONT,  32'sd0,          32'sd0,          ST_DONE,  5'd3),
      checked_row(REQ_POP_REAR,   32'sd0,          -32'sd1,         ST_DONE,  5'd2),
      checked_row(REQ_POP_FRONT,  32'sd0,          32'sh7FFF_FFFF,  ST_DONE,  5'd1),
      checked_row(REQ_POP_REAR,   32'sd0,          32'sh8000_0000,  ST_DONE,  5'd0),
      // tiny capacity: full refusals
      cap_row(5'd2),
      req_row(REQ_PUSH_REAR,      32'sh5555_5555),
      req_row(REQ_PUSH_FRONT,     32'shAAAA_AAAA),
      checked_row(REQ_PUSH_REAR,  32'sd1,          32'sd0,          ST_FULL,  5'd2),
      checked_row(REQ_PUSH_FRONT, 32'sd1,          32'sd0,          ST_FULL,  5'd2),
      req_row(REQ_POP_REAR,       32'sd0),
      // capacity zero with one word still held
      cap_row(5'd0),
      checked_row(REQ_PUSH_FRONT, 32'sd5,          32'sd0,          ST_FULL,  5'd1),
      req_row(REQ_POP_FRONT,      32'sd0),
      checked_row(REQ_POP_FRONT,  32'sd0,          32'sd0,          ST_EMPTY, 5'd0),
      checked_row(REQ_PUSH_REAR,  32'sd7,          32'sd0,          ST_FULL,  5'd0),
      // capacity above the built depth is clipped
      cap_row(5'd31),
      req_row(REQ_PUSH_REAR,      32'sh1234_5678),
      req_row(REQ_PUSH_FRONT,     -32'sd2),
      req_row(REQ_POP_REAR,       32'sd0),
      req_row(REQ_POP_FRONT,      32'sd0),
      cap_row(5'd16)
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        set_capacity(directed_rows[i].cap);
      else
        send_word(directed_rows[i].req, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // sender light, receiver heavy idling
    run_random(250, -1);
    set_capacity(5'd1);
    run_random(100, -1);

    // swapped idling, with one long receiver hold
    send_idle_pct = 48;
    recv_idle_pct = 20;
    set_capacity(5'd5);
    run_random(120, -1);
    hold_req = 1'b1;
    run_random(130, -1);
    set_capacity(5'd16);
    run_random(180, -1);
    run_random(20, 100);

    // no idling; capacity dropped below the held count first
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(5'd3);
    run_random(200, -1);
    set_capacity(5'd31);
    run_random(300, -1);
    set_capacity(5'd0);
    run_random(50, -1);
    set_capacity(5'd16);
    run_random(200, -1);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
src/deq_pkg.sv
src/deq_if.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue_unit.sv
verif/double_ended_queue_unit_tb.sv
